// ----- src/assert_macros.svh -----
// Assertion macros used by the converter top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ----- src/rgbcc_pkg.sv -----
// Shared types and constants of the RGB color space converter
`default_nettype none

package rgbcc_pkg;

    localparam int NUM_CELLS = 8;
    localparam int QUO_W     = NUM_CELLS;
    localparam int DIV_W     = 19;

    localparam logic [1:0] MODE_RGB = 2'd0;
    localparam logic [1:0] MODE_HSV = 2'd1;
    localparam logic [1:0] MODE_YIQ = 2'd2;

    localparam logic [15:0] Y_R = 16'd19595;
    localparam logic [15:0] Y_G = 16'd38470;
    localparam logic [15:0] Y_B = 16'd7471;
    localparam logic [15:0] I_R = 16'd39059;
    localparam logic [15:0] I_G = 16'd18022;
    localparam logic [15:0] I_B = 16'd21037;
    localparam logic [15:0] Q_R = 16'd13894;
    localparam logic [15:0] Q_G = 16'd34603;
    localparam logic [15:0] Q_B = 16'd20382;

    typedef struct packed {
        logic             hsv;
        logic             zero;
        logic             last;
        logic [7:0]       a;
        logic [7:0]       b;
        logic [7:0]       c;
        logic [DIV_W-1:0] s_rem;
        logic [DIV_W-1:0] s_div;
        logic [QUO_W-1:0] s_quo;
        logic [DIV_W-1:0] h_rem;
        logic [DIV_W-1:0] h_div;
        logic [QUO_W-1:0] h_quo;
    } cell_t;

endpackage

`default_nettype wire

// ----- src/rgb_color_space_converter.sv -----
// Top level of the RGB to HSV / YIQ color space converter
//
//  channel  dir  beat moves when      payload
//  s_       in   s_valid & s_ready    s_red_in, s_green_in, s_blue_in, s_last_pixel
//  m_       out  m_valid & m_ready    m_comp_a, m_comp_b, m_comp_c, m_last_out
//  cfg_     in   cfg_wr_en            cfg_wr_data (space_mode)
//
// One pixel per clock while the row is not stalled; a beat taken on s_ passes through
// one front stage and then a row of eight divider cells, one quotient bit each.
// The last cell's register is the output register; the whole row holds while
// m_valid is high and m_ready is low, and s_ready drops only then.
// Synchronous active-low reset clears the valid bits and space_mode to rgb.
`default_nettype none
`include "assert_macros.svh"

module rgb_color_space_converter
    import rgbcc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] cfg_wr_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_red_in,
    input  wire logic [7:0] s_green_in,
    input  wire logic [7:0] s_blue_in,
    input  wire logic       s_last_pixel,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_comp_a,
    output logic [7:0]      m_comp_b,
    output logic [7:0]      m_comp_c,
    output logic            m_last_out
);

    logic [1:0]         space_mode_reg;
    logic               advance;
    logic [NUM_CELLS:0] chain_valid;
    cell_t              chain_data [NUM_CELLS+1];
    cell_t              done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            space_mode_reg <= MODE_RGB;
        end else if (cfg_wr_en) begin
            space_mode_reg <= cfg_wr_data;
        end
    end

    assign advance = !chain_valid[NUM_CELLS] || m_ready;
    assign s_ready = advance;

    rgbcc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (s_valid),
        .red       (s_red_in),
        .green     (s_green_in),
        .blue      (s_blue_in),
        .last      (s_last_pixel),
        .mode      (space_mode_reg),
        .out_valid (chain_valid[0]),
        .out_data  (chain_data[0])
    );

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        rgbcc_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_valid  (chain_valid[k]),
            .in_data   (chain_data[k]),
            .out_valid (chain_valid[k+1]),
            .out_data  (chain_data[k+1])
        );
    end

    assign done       = chain_data[NUM_CELLS];
    assign m_valid    = chain_valid[NUM_CELLS];
    assign m_comp_a   = done.hsv ? (done.zero ? 8'd0 : done.h_quo) : done.a;
    assign m_comp_b   = done.hsv ? (done.zero ? 8'd0 : done.s_quo) : done.b;
    assign m_comp_c   = done.c;
    assign m_last_out = done.last;

    `ASSERT_CLK_ALWAYS(a_reset_clears_out, !aresetn |=> !m_valid, "output valid after reset")
    `ASSERT_CLK(a_accept_enters_front, s_valid && s_ready |=> chain_valid[0], "beat lost at front")
    `ASSERT_CLK(a_hsv_grey_hue_zero, m_valid && done.hsv && m_comp_b == 8'd0 |-> m_comp_a == 8'd0, "hue nonzero with zero saturation")
    `ASSERT_CLK(a_stall_holds_out, m_valid && !m_ready |=> m_valid && $stable(done.c), "result moved during stall")

endmodule

`default_nettype wire

// ----- src/rgbcc_front.sv -----
// Front stage: min/max, hue numerator, divider operands and YIQ matrix
`default_nettype none

module rgbcc_front
    import rgbcc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       advance,
    input  wire logic       in_valid,
    input  wire logic [7:0] red,
    input  wire logic [7:0] green,
    input  wire logic [7:0] blue,
    input  wire logic       last,
    input  wire logic [1:0] mode,
    output logic            out_valid,
    output cell_t           out_data
);

    function automatic logic [7:0] clamp_q16(input logic [25:0] pos, input logic [25:0] neg);
        logic [25:0] diff;
        diff = pos - neg;
        if (pos < neg) begin
            return 8'd0;
        end else if (diff[25:16] > 10'd255) begin
            return 8'd255;
        end
        return diff[23:16];
    endfunction

    logic        valid_reg;
    cell_t       data_reg;
    cell_t       data_next;
    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [7:0]  delta;
    logic [10:0] delta6;
    logic [11:0] num;
    logic [25:0] y_sum;
    logic [25:0] i_pos;
    logic [25:0] i_neg;
    logic [25:0] q_pos;
    logic [25:0] q_neg;

    always_comb begin
        mx = red;
        mn = red;
        if (green > mx) mx = green;
        if (blue > mx) mx = blue;
        if (green < mn) mn = green;
        if (blue < mn) mn = blue;
        delta  = mx - mn;
        delta6 = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};

        if (red == mx) begin
            num = 12'(green) - 12'(blue);
            if (green < blue) num = num + 12'(delta6);
        end else if (green == mx) begin
            num = 12'({delta, 1'b0}) + 12'(blue) - 12'(red);
        end else begin
            num = 12'({delta, 2'b00}) + 12'(red) - 12'(green);
        end

        y_sum = 26'(Y_R) * 26'(red) + 26'(Y_G) * 26'(green) + 26'(Y_B) * 26'(blue);
        i_pos = 26'(I_R) * 26'(red);
        i_neg = 26'(I_G) * 26'(green) + 26'(I_B) * 26'(blue);
        q_pos = 26'(Q_R) * 26'(red) + 26'(Q_B) * 26'(blue);
        q_neg = 26'(Q_G) * 26'(green);

        data_next       = '0;
        data_next.last  = last;
        data_next.zero  = (delta == 8'd0);
        data_next.s_rem = DIV_W'({delta, 8'b0}) - DIV_W'(delta);
        data_next.s_div = DIV_W'({mx, 7'b0});
        data_next.h_rem = DIV_W'({num, 8'b0}) - DIV_W'(num);
        data_next.h_div = DIV_W'({delta6, 7'b0});
        unique case (mode)
            MODE_HSV: begin
                data_next.hsv = 1'b1;
                data_next.a   = 8'd0;
                data_next.b   = 8'd0;
                data_next.c   = mx;
            end
            MODE_YIQ: begin
                data_next.a = y_sum[23:16];
                data_next.b = clamp_q16(i_pos, i_neg);
                data_next.c = clamp_q16(q_pos, q_neg);
            end
            default: begin
                data_next.a = red;
                data_next.b = green;
                data_next.c = blue;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
        if (advance) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ----- src/rgbcc_div_cell.sv -----
// Divider cell: one quotient bit of saturation and of hue per stage
`default_nettype none

module rgbcc_div_cell
    import rgbcc_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  advance,
    input  wire logic  in_valid,
    input  cell_t      in_data,
    output logic       out_valid,
    output cell_t      out_data
);

    logic  valid_reg;
    cell_t data_reg;
    cell_t data_next;
    logic  s_bit;
    logic  h_bit;

    always_comb begin
        data_next = in_data;
        s_bit     = (in_data.s_rem >= in_data.s_div);
        h_bit     = (in_data.h_rem >= in_data.h_div);
        if (s_bit) data_next.s_rem = in_data.s_rem - in_data.s_div;
        if (h_bit) data_next.h_rem = in_data.h_rem - in_data.h_div;
        data_next.s_div = in_data.s_div >> 1;
        data_next.h_div = in_data.h_div >> 1;
        data_next.s_quo = {in_data.s_quo[QUO_W-2:0], s_bit};
        data_next.h_quo = {in_data.h_quo[QUO_W-2:0], h_bit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
        if (advance) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ----- sim/tb_rgb_color_space_converter.sv -----
// Testbench for rgb_color_space_converter: directed and random pixels vs. a local HSV/YIQ model
`timescale 1ns / 100ps

module tb_rgb_color_space_converter;
    import rgbcc_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 10;
    localparam int DRAIN_CYCLES   = 12;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASES         = 10;
    localparam int PHASE_PIXELS   = 110;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int W_YR = 19595;
    localparam int W_YG = 38470;
    localparam int W_YB = 7471;
    localparam int W_IR = 39059;
    localparam int W_IG = 18022;
    localparam int W_IB = 21037;
    localparam int W_QR = 13894;
    localparam int W_QG = 34603;
    localparam int W_QB = 20382;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic       last;
    } comp_t;

    class pixel_scoreboard;
        comp_t      expected_q[$];
        logic [1:0] mode;
        int         faults;
        int         checked;
        int         pixels_per_mode[4];

        function new();
            mode = MODE_RGB;
            faults = 0;
            checked = 0;
            foreach (pixels_per_mode[i]) pixels_per_mode[i] = 0;
        endfunction

        function void set_mode(logic [1:0] m);
            mode = m;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [7:0] sat_q16(int acc);
            if (acc < 0) return 8'd0;
            acc = acc >> 16;
            return (acc > 255) ? 8'd255 : acc[7:0];
        endfunction

        function comp_t convert(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
            comp_t res;
            int    ri, gi, bi, hi, lo, delta, hue;
            ri = r;
            gi = g;
            bi = b;
            res.a = r;
            res.b = g;
            res.c = b;
            res.last = last;
            case (mode)
                MODE_HSV: begin
                    hi = (ri > gi) ? ri : gi;
                    hi = (bi > hi) ? bi : hi;
                    lo = (ri < gi) ? ri : gi;
                    lo = (bi < lo) ? bi : lo;
                    delta = hi - lo;
                    res.c = hi[7:0];
                    if (hi == 0 || delta == 0) begin
                        res.a = 8'd0;
                        res.b = 8'd0;
                    end else begin
                        res.b = 8'((255 * delta) / hi);
                        if (ri == hi)
                            hue = gi - bi;
                        else if (gi == hi)
                            hue = 2 * delta + bi - ri;
                        else
                            hue = 4 * delta + ri - gi;
                        if (hue < 0) hue += 6 * delta;
                        res.a = 8'((255 * hue) / (6 * delta));
                    end
                end
                MODE_YIQ: begin
                    res.a = sat_q16(W_YR * ri + W_YG * gi + W_YB * bi);
                    res.b = sat_q16(W_IR * ri - W_IG * gi - W_IB * bi);
                    res.c = sat_q16(W_QR * ri - W_QG * gi + W_QB * bi);
                end
                default: ;
            endcase
            return res;
        endfunction

        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
            expected_q.push_back(convert(r, g, b, last));
            pixels_per_mode[mode]++;
        endfunction

        function void check_result(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic last);
            comp_t want;
            if (expected_q.size() == 0) begin
                faults++;
                if (faults <= REPORT_LIMIT)
                    $display("t=%0t unexpected beat: a=%0d b=%0d c=%0d last=%0b",
                             $time, a, b, c, last);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (want.a !== a || want.b !== b || want.c !== c || want.last !== last) begin
                faults++;
                if (faults <= REPORT_LIMIT)
                    $display("t=%0t mismatch: expected a=%0d b=%0d c=%0d last=%0b, got a=%0d b=%0d c=%0d last=%0b",
                             $time, want.a, want.b, want.c, want.last, a, b, c, last);
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    logic [1:0] cfg_wr_data;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_red_in;
    logic [7:0] s_green_in;
    logic [7:0] s_blue_in;
    logic       s_last_pixel;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_comp_a;
    logic [7:0] m_comp_b;
    logic [7:0] m_comp_c;
    logic       m_last_out;

    pixel_scoreboard book = new();

    logic       tx_gaps;
    logic       rx_stalls;
    logic       rx_hold_req;
    logic       in_beat;
    logic       out_beat;
    int         idle_cycles;
    int         mode_writes;
    logic [1:0] phase_modes [PHASES] = '{MODE_HSV, MODE_YIQ, MODE_RGB, MODE_SPARE, MODE_YIQ,
                                         MODE_HSV, MODE_HSV, MODE_YIQ, MODE_HSV, MODE_YIQ};

    rgb_color_space_converter dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_red_in     (s_red_in),
        .s_green_in   (s_green_in),
        .s_blue_in    (s_blue_in),
        .s_last_pixel (s_last_pixel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_comp_a     (m_comp_a),
        .m_comp_b     (m_comp_b),
        .m_comp_c     (m_comp_c),
        .m_last_out   (m_last_out)
    );

    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // sample at the falling edge; nothing the bench drives moves before the next rising edge
    always @(negedge aclk) begin
        in_beat  = aresetn && s_valid && s_ready;
        out_beat = aresetn && m_valid && m_ready;
        if (out_beat) book.check_result(m_comp_a, m_comp_b, m_comp_c, m_last_out);
    end

    always @(posedge aclk) begin
        if (in_beat || out_beat)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     idle_cycles, book.pending());
            $display("[rgb_color_space_converter] ERROR");
            $finish;
        end
    end

    initial begin : ready_driver
        int run;
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (rx_hold_req) begin
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                rx_hold_req = 1'b0;
            end else begin
                run = $urandom_range(1, 24);
                m_ready <= 1'b1;
                repeat (run) @(posedge aclk);
                stall = rx_stalls ? gap_len() : 0;
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
        end
    end

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic last);
        int   gap;
        logic taken;
        gap = tx_gaps ? gap_len() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_red_in     <= r;
        s_green_in   <= g;
        s_blue_in    <= b;
        s_last_pixel <= last;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
        book.note_pixel(r, g, b, last);
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (book.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        wait_drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        book.set_mode(m);
        mode_writes++;
    endtask

    task automatic make_pixel(output logic [7:0] r, output logic [7:0] g, output logic [7:0] b);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = 8'($urandom);
        lo = 8'($urandom_range(0, hi));
        r  = 8'($urandom);
        g  = 8'($urandom);
        b  = 8'($urandom);
        case ($urandom_range(0, 9))
            0: begin
                g = r;
                b = r;
            end
            1: begin
                case ($urandom_range(0, 2))
                    0:       begin r = hi; g = hi; b = lo; end
                    1:       begin r = lo; g = hi; b = hi; end
                    default: begin r = hi; g = lo; b = hi; end
                endcase
            end
            2: begin
                r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            3: begin
                g = r + 8'($urandom_range(0, 2));
                b = r - 8'($urandom_range(0, 2));
            end
            default: ;
        endcase
    endtask

    initial begin : stimulus
        int         phase;
        int         n;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;

        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = MODE_RGB;
        s_valid      = 1'b0;
        s_red_in     = 8'd0;
        s_green_in   = 8'd0;
        s_blue_in    = 8'd0;
        s_last_pixel = 1'b0;
        tx_gaps      = 1'b1;
        rx_stalls    = 1'b1;
        rx_hold_req  = 1'b0;
        in_beat      = 1'b0;
        out_beat     = 1'b0;
        idle_cycles  = 0;
        mode_writes  = 0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        send_pixel(8'd0, 8'd255, 8'd17, 1'b1);
        send_pixel(8'd255, 8'd0, 8'd255, 1'b0);

        write_mode(MODE_HSV);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
        send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd0, 8'd255, 8'd0, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd0, 1'b0);
        send_pixel(8'd0, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd0, 8'd255, 1'b1);
        send_pixel(8'd200, 8'd10, 8'd90, 1'b0);
        send_pixel(8'd1, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd37, 8'd200, 8'd199, 1'b1);

        write_mode(MODE_YIQ);
        send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd0, 8'd255, 8'd0, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        send_pixel(8'd100, 8'd20, 8'd240, 1'b0);

        write_mode(MODE_SPARE);
        send_pixel(8'd255, 8'd128, 8'd0, 1'b0);
        send_pixel(8'd3, 8'd250, 8'd77, 1'b1);

        for (phase = 0; phase < PHASES; phase++) begin
            write_mode(phase_modes[phase]);
            tx_gaps   = (phase % 4) != 2;
            rx_stalls = tx_gaps;
            for (n = 0; n < PHASE_PIXELS; n++) begin
                if (phase == 6 && n == 30) rx_hold_req = 1'b1;
                if (phase == 7 && n == 55) wait_drain();
                make_pixel(r, g, b);
                send_pixel(r, g, b, $urandom_range(0, 15) == 0);
            end
        end

        wait_drain();
        $display("Converted %0d pixels, checked %0d beats, %0d mode writes incl. unused code",
                 book.checked + book.pending(), book.checked, mode_writes);
        $display("Pixels per mode: rgb %0d, hsv %0d, yiq %0d, unused %0d; long output hold-off and drain pause done",
                 book.pixels_per_mode[MODE_RGB], book.pixels_per_mode[MODE_HSV],
                 book.pixels_per_mode[MODE_YIQ], book.pixels_per_mode[MODE_SPARE]);
        if (book.faults == 0 && book.pending() == 0)
            $display("[rgb_color_space_converter] OK");
        else
            $display("[rgb_color_space_converter] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/rgbcc_pkg.sv
src/rgbcc_front.sv
src/rgbcc_div_cell.sv
src/rgb_color_space_converter.sv
sim/tb_rgb_color_space_converter.sv
